// ----- hdl/rzps_pkg.sv -----
package rzps_pkg;

	localparam int PRICE_BITS = 24;
	localparam int WINDOW     = 8;

	localparam int THR_W    = 12;
	localparam int SIG_W    = 3;
	localparam int SPREAD_W = PRICE_BITS + 1;
	localparam int SQ_W     = 2 * PRICE_BITS;
	localparam int SLOT_W   = $clog2(WINDOW);
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int SUM_W    = SPREAD_W + $clog2(WINDOW);
	localparam int Q_W      = SQ_W + $clog2(WINDOW);
	localparam int D_W      = SUM_W + 1;
	localparam int DM_W     = SUM_W;
	localparam int NQ_W     = Q_W + $clog2(WINDOW);
	localparam int DEV_W    = NQ_W;
	localparam int DLO_W    = (DEV_W + 1) / 2;
	localparam int DHI_W    = DEV_W - DLO_W;
	localparam int T2_W     = 2 * THR_W;
	localparam int TH_W     = DEV_W + T2_W;
	localparam int LHS_W    = 2 * DM_W + 16;
	localparam int MUL_W0   = (DM_W > DLO_W) ? DM_W : DLO_W;
	localparam int MUL_W    = (MUL_W0 > T2_W) ? MUL_W0 : T2_W;
	localparam int PROD_W   = 2 * MUL_W;

	localparam logic [SIG_W-1:0] SIG_WARMING = 3'd0;
	localparam logic [SIG_W-1:0] SIG_ABOVE   = 3'd1;
	localparam logic [SIG_W-1:0] SIG_BELOW   = 3'd2;
	localparam logic [SIG_W-1:0] SIG_CLOSE   = 3'd3;
	localparam logic [SIG_W-1:0] SIG_NONE    = 3'd4;

	localparam logic REG_ENTER = 1'b0;
	localparam logic REG_EXIT  = 1'b1;

	localparam logic [THR_W-1:0] ENTER_RESET = 12'd256;
	localparam logic [THR_W-1:0] EXIT_RESET  = 12'd205;

	typedef enum logic [12:0] {
		ST_IDLE = 13'h0001,
		ST_X2   = 13'h0002,
		ST_OLD2 = 13'h0004,
		ST_S2   = 13'h0008,
		ST_D2   = 13'h0010,
		ST_TE   = 13'h0020,
		ST_TX   = 13'h0040,
		ST_ELO  = 13'h0080,
		ST_EHI  = 13'h0100,
		ST_XLO  = 13'h0200,
		ST_XHI  = 13'h0400,
		ST_CMP  = 13'h0800,
		ST_DONE = 13'h1000
	} state_t;

endpackage

// ----- hdl/rolling_zscore_pair_signal_top.sv -----
// One item is in work at a time: in_ready is high only in ST_IDLE, and a stalled result holds the FSM in ST_DONE.
// With a full window the FSM runs through every product state; while warming it goes from ST_OLD2 to ST_DONE.
// A single shared 28x28 multiplier forms the ten products in turn with a full window.
// Reset (arst_n low, asynchronous): window empty, sums zero, thresholds 1.0 and 205/256.
// Window contents are not cleared; a slot's read value is used only after the slot has been written.
module rolling_zscore_pair_signal_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rzps_pkg::PRICE_BITS-1:0]  price_a,
	input  logic [rzps_pkg::PRICE_BITS-1:0]  price_b,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [rzps_pkg::SIG_W-1:0]       signal,
	output logic signed [rzps_pkg::SPREAD_W-1:0] spread,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_index,
	input  logic [rzps_pkg::THR_W-1:0]       cfg_data
);
	import rzps_pkg::*;

	state_t state_q;

	logic signed [SPREAD_W-1:0] window_mem [WINDOW];

	logic [SLOT_W-1:0]          slot_q;
	logic [FILL_W-1:0]          fill_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [Q_W-1:0]             sqsum_q;
	logic [THR_W-1:0]           enter_q;
	logic [THR_W-1:0]           exit_q;

	logic signed [SPREAD_W-1:0] x_q;
	logic signed [SPREAD_W-1:0] old_q;
	logic signed [D_W-1:0]      d_q;
	logic [SQ_W-1:0]            x2_q;
	logic [SQ_W-1:0]            o2_q;
	logic [DEV_W-1:0]           dev_q;
	logic [LHS_W-1:0]           lhs_q;
	logic [T2_W-1:0]            t2e_q;
	logic [T2_W-1:0]            t2x_q;
	logic [TH_W-1:0]            acc_q;
	logic [TH_W-1:0]            te_q;
	logic [PROD_W-1:0]          prod_q;
	logic [SIG_W-1:0]           sig_q;

	logic                       out_valid_q;
	logic [SIG_W-1:0]           signal_q;
	logic signed [SPREAD_W-1:0] spread_q;

	logic [MUL_W-1:0]           mul_a;
	logic [MUL_W-1:0]           mul_b;
	logic [PROD_W-1:0]          prod_c;

	logic [SPREAD_W-1:0]        xm;
	logic [SPREAD_W-1:0]        om;
	logic [SUM_W-1:0]           sm;
	logic [D_W-1:0]             dm;
	logic [NQ_W-1:0]            nq;
	logic [NQ_W-1:0]            s2;
	logic [TH_W-1:0]            lhs_ext;
	logic [TH_W-1:0]            tx;
	logic                       warming;
	logic                       in_beat;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign signal    = signal_q;
	assign spread    = spread_q;

	assign warming = (fill_q < FILL_W'(WINDOW));

	assign xm = x_q[SPREAD_W-1] ? -x_q : x_q;
	assign om = old_q[SPREAD_W-1] ? -old_q : old_q;
	assign sm = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign dm = d_q[D_W-1] ? -d_q : d_q;

	assign nq      = NQ_W'(sqsum_q) * NQ_W'(WINDOW);
	assign s2      = prod_q[NQ_W-1:0];
	assign lhs_ext = TH_W'(lhs_q);
	assign tx      = acc_q + (TH_W'(prod_q[DHI_W+T2_W-1:0]) << DLO_W);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_X2: begin
				mul_a = MUL_W'(xm);
				mul_b = MUL_W'(xm);
			end
			ST_OLD2: begin
				mul_a = MUL_W'(om);
				mul_b = MUL_W'(om);
			end
			ST_S2: begin
				mul_a = MUL_W'(sm);
				mul_b = MUL_W'(sm);
			end
			ST_D2: begin
				mul_a = MUL_W'(dm[DM_W-1:0]);
				mul_b = MUL_W'(dm[DM_W-1:0]);
			end
			ST_TE: begin
				mul_a = MUL_W'(enter_q);
				mul_b = MUL_W'(enter_q);
			end
			ST_TX: begin
				mul_a = MUL_W'(exit_q);
				mul_b = MUL_W'(exit_q);
			end
			ST_ELO: begin
				mul_a = MUL_W'(dev_q[DLO_W-1:0]);
				mul_b = MUL_W'(t2e_q);
			end
			ST_EHI: begin
				mul_a = MUL_W'(dev_q[DEV_W-1:DLO_W]);
				mul_b = MUL_W'(t2e_q);
			end
			ST_XLO: begin
				mul_a = MUL_W'(dev_q[DLO_W-1:0]);
				mul_b = MUL_W'(t2x_q);
			end
			ST_XHI: begin
				mul_a = MUL_W'(dev_q[DEV_W-1:DLO_W]);
				mul_b = MUL_W'(t2x_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_c = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
	end

	// window ring: registered read at accept, write at commit
	always_ff @(posedge clk) begin
		if (in_beat) begin
			old_q <= window_mem[slot_q];
		end
		if ((state_q == ST_CMP) || (state_q == ST_OLD2 && warming)) begin
			window_mem[slot_q] <= x_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat) begin
					x_q <= SPREAD_W'($signed({1'b0, price_a})) - SPREAD_W'($signed({1'b0, price_b}));
				end
			end
			ST_X2: begin
				d_q <= D_W'(x_q) * D_W'(WINDOW) - D_W'(sum_q);
			end
			ST_OLD2: begin
				x2_q <= prod_q[SQ_W-1:0];
				if (warming) begin
					sig_q <= SIG_WARMING;
				end
			end
			ST_S2: begin
				o2_q <= prod_q[SQ_W-1:0];
			end
			ST_D2: begin
				dev_q <= (nq >= s2) ? (nq - s2) : '0;
			end
			ST_TE: begin
				lhs_q <= {prod_q[2*DM_W-1:0], 16'b0};
			end
			ST_TX: begin
				t2e_q <= prod_q[T2_W-1:0];
			end
			ST_ELO: begin
				t2x_q <= prod_q[T2_W-1:0];
			end
			ST_EHI: begin
				acc_q <= TH_W'(prod_q[DLO_W+T2_W-1:0]);
			end
			ST_XLO: begin
				te_q <= acc_q + (TH_W'(prod_q[DHI_W+T2_W-1:0]) << DLO_W);
			end
			ST_XHI: begin
				acc_q <= TH_W'(prod_q[DLO_W+T2_W-1:0]);
			end
			ST_CMP: begin
				priority if (!d_q[D_W-1] && (d_q != '0) && (te_q < lhs_ext)) begin
					sig_q <= SIG_ABOVE;
				end else if (d_q[D_W-1] && (te_q < lhs_ext)) begin
					sig_q <= SIG_BELOW;
				end else if (lhs_ext < tx) begin
					sig_q <= SIG_CLOSE;
				end else begin
					sig_q <= SIG_NONE;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sqsum_q     <= '0;
			enter_q     <= ENTER_RESET;
			exit_q      <= EXIT_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_ENTER: enter_q <= cfg_data;
					REG_EXIT:  exit_q  <= cfg_data;
				endcase
			end
			if (state_q == ST_DONE) begin
				if (!out_valid_q || out_ready) begin
					out_valid_q <= 1'b1;
				end
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= ST_X2;
					end
				end
				ST_X2:  state_q <= ST_OLD2;
				ST_OLD2: begin
					if (warming) begin
						sum_q   <= sum_q + SUM_W'(x_q);
						sqsum_q <= sqsum_q + Q_W'(prod_q[SQ_W-1:0]);
						fill_q  <= fill_q + 1'b1;
						slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_S2;
					end
				end
				ST_S2:  state_q <= ST_D2;
				ST_D2:  state_q <= ST_TE;
				ST_TE:  state_q <= ST_TX;
				ST_TX:  state_q <= ST_ELO;
				ST_ELO: state_q <= ST_EHI;
				ST_EHI: state_q <= ST_XLO;
				ST_XLO: state_q <= ST_XHI;
				ST_XHI: state_q <= ST_CMP;
				ST_CMP: begin
					sum_q   <= sum_q + SUM_W'(x_q) - SUM_W'(old_q);
					sqsum_q <= sqsum_q + Q_W'(x2_q) - Q_W'(o2_q);
					slot_q  <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			signal_q <= sig_q;
			spread_q <= x_q;
		end
	end

endmodule

// ----- hdl/rzps_checker.sv -----
module rzps_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [rzps_pkg::SIG_W-1:0]            signal,
	input logic signed [rzps_pkg::SPREAD_W-1:0]  spread
);
	import rzps_pkg::*;

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(signal) && $stable(spread))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without an item in work");

	a_signal_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (signal == SIG_WARMING || signal == SIG_ABOVE ||
			signal == SIG_BELOW || signal == SIG_CLOSE || signal == SIG_NONE))
		else $error("bad signal code");

endmodule

bind rolling_zscore_pair_signal_top rzps_checker u_rzps_checker (.*);
